### design/link_quality_bitrate_adapter_defines.svh
// Assertion macros shared by the design files.
`ifndef LINK_QUALITY_BITRATE_ADAPTER_DEFINES_SVH
`define LINK_QUALITY_BITRATE_ADAPTER_DEFINES_SVH
`ifndef SYNTHESIS
`define LQBA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LQBA_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LQBA_ASSERT(label, clk, rst_n, prop, msg)
`define LQBA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### design/lqba_pkg.sv
package lqba_pkg;

	localparam logic [1:0] REQ_REPORT = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_STOP   = 2'd2;

	localparam logic [15:0] RATE_FLOOR   = 16'd1000;
	localparam logic [6:0]  FULL_QUALITY = 7'd100;
	localparam logic [15:0] MAX_RESET    = 16'd5000;

	localparam int DIV_W = 64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV_Q,
		ST_DIV_FULL,
		ST_APPLY,
		ST_START_BW,
		ST_DIV_BW,
		ST_DIV_RATE,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the input item
		logic start_q;     // divide c*q by p
		logic start_full;  // divide c*c by m
		logic apply;       // apply delta, bump count, sums
		logic start_bw;    // divide bandwidth difference by count
		logic start_rate;  // divide rate difference by count
		logic do_start;    // start event
		logic do_stop;     // stop event
		logic finish;      // commit rate mean and last quality
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic rule_q;
		logic rule_full;
	} status_t;

endpackage

### design/lqba_divider.sv
// Restoring divider, one quotient bit per cycle.
module lqba_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lqba_pkg::DIV_W-1:0]     dividend,
	input  logic [lqba_pkg::DIV_W-1:0]     divisor,
	output logic                           busy,
	output logic [lqba_pkg::DIV_W-1:0]     quotient
);
	localparam int CW = $clog2(lqba_pkg::DIV_W + 1);

	logic [lqba_pkg::DIV_W-1:0] quo_q;
	logic [lqba_pkg::DIV_W-1:0] rem_q;
	logic [lqba_pkg::DIV_W-1:0] den_q;
	logic [CW-1:0]              cnt_q;
	logic [lqba_pkg::DIV_W+1:0] trial;

	assign trial    = {1'b0, rem_q, quo_q[lqba_pkg::DIV_W-1]} - {2'b00, den_q};
	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(lqba_pkg::DIV_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy) begin
			if (!trial[lqba_pkg::DIV_W+1]) begin
				rem_q <= trial[lqba_pkg::DIV_W-1:0];
				quo_q <= {quo_q[lqba_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[lqba_pkg::DIV_W-2:0], quo_q[lqba_pkg::DIV_W-1]};
				quo_q <= {quo_q[lqba_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end
endmodule

### design/lqba_datapath.sv
`include "link_quality_bitrate_adapter_defines.svh"
module lqba_datapath #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lqba_pkg::cmd_t       cmd,
	output lqba_pkg::status_t    status,
	input  logic [15:0]          max_bitrate,
	input  logic [1:0]           req_type,
	input  logic [14:0]          link_quality,
	input  logic [30:0]          link_bandwidth,
	input  logic [30:0]          retransmitted_count,
	input  logic [30:0]          sent_count,
	output logic [15:0]          encode_bitrate,
	output logic                 bitrate_changed,
	output logic [30:0]          bandwidth_average,
	output logic [15:0]          bitrate_average,
	output logic [31:0]          retransmitted_total,
	output logic [31:0]          sent_total
);
	localparam int W = lqba_pkg::DIV_W;

	logic [14:0] q_q;
	logic [30:0] bw_q;
	logic [30:0] rt_q;
	logic [30:0] st_q;
	logic [15:0] rate_q;
	logic [14:0] lastq_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [30:0] bwmean_q;
	logic [15:0] ratemean_q;
	logic [31:0] rsum_q;
	logic [31:0] ssum_q;
	logic        changed_q;
	logic        full_q;   // the full quality rule ran for this report
	logic        bw_neg_q;
	logic        rate_neg_q;

	logic          div_start;
	logic [W-1:0]  div_num;
	logic [W-1:0]  div_den;
	logic          div_busy;
	logic [W-1:0]  div_quo;

	logic [31:0]   product;
	logic          rule_q;
	logic          rule_full;
	logic signed [33:0] delta;
	logic signed [33:0] rsum;
	logic [15:0]   rnew;
	logic [15:0]   rclamp;
	logic [30:0]   bw_diff;
	logic [15:0]   rate_diff;
	logic [30:0]   bw_mean_next;
	logic [15:0]   rate_mean_next;

	assign rule_q    = (lastq_q != '0) && (q_q[14:8] != lastq_q[14:8]);
	assign rule_full = (lastq_q[14:8] == lqba_pkg::FULL_QUALITY)
		&& (q_q[14:8] == lqba_pkg::FULL_QUALITY) && (rate_q < max_bitrate);
	assign status = '{div_busy: div_busy, rule_q: rule_q, rule_full: rule_full};

	assign product = cmd.start_full ? (32'(rate_q) * 32'(rate_q))
	                                : (32'(rate_q) * 32'(q_q));

	// Operand selection for the shared divider.
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = W'(1);
		if (cmd.start_q || cmd.start_full) begin
			div_start = 1'b1;
			div_num   = W'(product);
			div_den   = cmd.start_full ? W'(max_bitrate) : W'(lastq_q);
		end else if (cmd.start_bw) begin
			div_start = 1'b1;
			div_num   = W'(bw_diff);
			div_den   = W'(count_q);
		end else if (cmd.start_rate) begin
			div_start = 1'b1;
			div_num   = W'(rate_diff);
			div_den   = W'(count_q);
		end
	end

	lqba_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Delta from the finished quotient; full_q remembers which rule ran.
	always_comb begin
		delta = '0;
		if (full_q) begin
			delta = $signed({2'b0, div_quo[31:0]});
		end else if (rule_q) begin
			delta = $signed({2'b0, div_quo[31:0]}) - $signed({18'b0, rate_q});
		end
		rsum   = $signed({18'b0, rate_q}) + (delta / 34'sd2);
		rnew   = rsum[15:0];
		rclamp = (rnew > max_bitrate) ? max_bitrate : rnew;
		if (rclamp < lqba_pkg::RATE_FLOOR) begin
			rclamp = lqba_pkg::RATE_FLOOR;
		end
	end

	assign bw_diff   = bw_neg_q ? (bwmean_q - bw_q) : (bw_q - bwmean_q);
	assign rate_diff = rate_neg_q ? (ratemean_q - rate_q) : (rate_q - ratemean_q);
	assign bw_mean_next   = bw_neg_q ? (bwmean_q - div_quo[30:0])
	                                 : (bwmean_q + div_quo[30:0]);
	assign rate_mean_next = rate_neg_q ? (ratemean_q - div_quo[15:0])
	                                   : (ratemean_q + div_quo[15:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q  <= link_quality;
			bw_q <= link_bandwidth;
			rt_q <= retransmitted_count;
			st_q <= sent_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= '0;
			lastq_q    <= '0;
			count_q    <= '0;
			bwmean_q   <= '0;
			ratemean_q <= '0;
			rsum_q     <= '0;
			ssum_q     <= '0;
			changed_q  <= 1'b0;
			full_q     <= 1'b0;
			bw_neg_q   <= 1'b0;
			rate_neg_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				changed_q <= 1'b0;
				full_q    <= 1'b0;
			end
			if (cmd.do_start) begin
				rate_q <= max_bitrate;
			end
			if (cmd.do_stop) begin
				count_q    <= '0;
				bwmean_q   <= '0;
				ratemean_q <= '0;
				rsum_q     <= '0;
				ssum_q     <= '0;
			end
			if (cmd.start_full) begin
				full_q <= 1'b1;
			end
			if (cmd.apply) begin
				if (((rule_q || full_q) && delta != '0) || (rate_q > max_bitrate)) begin
					rate_q    <= rclamp;
					changed_q <= 1'b1;
				end
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
				rsum_q   <= rsum_q + 32'(rt_q);
				ssum_q   <= ssum_q + 32'(st_q);
				bw_neg_q <= (bw_q < bwmean_q);
			end
			if (cmd.start_bw) begin
				rate_neg_q <= (rate_q < ratemean_q);
			end
			if (cmd.start_rate) begin
				bwmean_q <= bw_mean_next;
			end
			if (cmd.finish && req_type == lqba_pkg::REQ_REPORT) begin
				ratemean_q <= rate_mean_next;
				lastq_q    <= q_q;
			end
		end
	end

	assign encode_bitrate      = rate_q;
	assign bitrate_changed     = changed_q;
	assign bandwidth_average   = bwmean_q;
	assign bitrate_average     = ratemean_q;
	assign retransmitted_total = rsum_q;
	assign sent_total          = ssum_q;

	`LQBA_ASSERT(a_rate_floor, clk, arst_n, $rose(changed_q) |-> (rate_q >= lqba_pkg::RATE_FLOOR), "changed rate below floor")
	`LQBA_ASSERT(a_changed_rate, clk, arst_n, $rose(changed_q) |-> (rate_q >= lqba_pkg::RATE_FLOOR) || (rate_q <= max_bitrate), "changed rate out of range")
	`LQBA_ASSERT(a_stop_clears, clk, arst_n, $past(cmd.do_stop) |-> (count_q == '0) && (rsum_q == '0), "stop did not clear figures")
endmodule

### design/lqba_control.sv
`include "link_quality_bitrate_adapter_defines.svh"
module lqba_control (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  lqba_pkg::status_t    status,
	output lqba_pkg::cmd_t       cmd
);
	lqba_pkg::state_t state_q, state_d;
	logic [1:0] kind_q;
	logic       out_valid_q;
	logic       out_load;

	assign in_stall  = (state_q != lqba_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lqba_pkg::ST_IDLE;
			kind_q      <= lqba_pkg::REQ_REPORT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				kind_q <= req_type;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		out_load = 1'b0;
		unique case (state_q)
			lqba_pkg::ST_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.load = 1'b1;
					state_d  = lqba_pkg::ST_DECIDE;
				end
			end
			lqba_pkg::ST_DECIDE: begin
				if (kind_q == lqba_pkg::REQ_REPORT) begin
					if (status.rule_full) begin
						cmd.start_full = 1'b1;
						state_d        = lqba_pkg::ST_DIV_FULL;
					end else if (status.rule_q) begin
						cmd.start_q = 1'b1;
						state_d     = lqba_pkg::ST_DIV_Q;
					end else begin
						state_d = lqba_pkg::ST_APPLY;
					end
				end else begin
					cmd.do_start = (kind_q == lqba_pkg::REQ_START);
					cmd.do_stop  = (kind_q == lqba_pkg::REQ_STOP);
					state_d      = lqba_pkg::ST_OUT;
				end
			end
			lqba_pkg::ST_DIV_Q, lqba_pkg::ST_DIV_FULL: begin
				if (!status.div_busy) begin
					state_d = lqba_pkg::ST_APPLY;
				end
			end
			lqba_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = lqba_pkg::ST_START_BW;
			end
			// The bandwidth division needs the count and sign from the apply step.
			lqba_pkg::ST_START_BW: begin
				cmd.start_bw = 1'b1;
				state_d      = lqba_pkg::ST_DIV_BW;
			end
			lqba_pkg::ST_DIV_BW: begin
				if (!status.div_busy) begin
					cmd.start_rate = 1'b1;
					state_d        = lqba_pkg::ST_DIV_RATE;
				end
			end
			lqba_pkg::ST_DIV_RATE: begin
				if (!status.div_busy) begin
					cmd.finish = 1'b1;
					state_d    = lqba_pkg::ST_OUT;
				end
			end
			lqba_pkg::ST_OUT: begin
				if (!(out_valid_q && out_stall)) begin
					out_load = 1'b1;
					state_d  = lqba_pkg::ST_IDLE;
				end
			end
			default: state_d = lqba_pkg::ST_IDLE;
		endcase
	end

	`LQBA_ASSERT(a_one_cmd_div, clk, arst_n, $countones({cmd.start_q, cmd.start_full, cmd.start_bw, cmd.start_rate}) <= 1, "two divisions started at once")
	`LQBA_ASSERT(a_load_idle, clk, arst_n, cmd.load |-> state_q == lqba_pkg::ST_IDLE, "item loaded while busy")
	`LQBA_ASSERT(a_out_hold, clk, arst_n, out_load |-> !(out_valid_q && out_stall), "result overwritten")
endmodule

### design/link_quality_bitrate_adapter.sv
// Link quality bitrate adapter. Each item (statistics report, stream start
// or stream stop) yields exactly one result carrying the encoder bitrate and
// the running statistics. One item is handled at a time. A start or stop
// item passes through the decide and output states only. A report waits on
// the shared 64-bit restoring divider, which works one bit per cycle, for
// the quality ratio (only when a quality rule fires) and for each of the
// two averages. A stalled result holds off the next item.
// max_bitrate sits at APB byte address 0 and should be written only while
// the block is idle.
module link_quality_bitrate_adapter #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [14:0] link_quality,
	input  logic [30:0] link_bandwidth,
	input  logic [30:0] retransmitted_count,
	input  logic [30:0] sent_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] encode_bitrate,
	output logic        bitrate_changed,
	output logic [30:0] bandwidth_average,
	output logic [15:0] bitrate_average,
	output logic [31:0] retransmitted_total,
	output logic [31:0] sent_total
);
	lqba_pkg::cmd_t    cmd;
	lqba_pkg::status_t status;
	logic [15:0]       max_q;
	logic [1:0]        kind_q;

	// The only register is at address 0; other addresses read as zero.
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'd0, max_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= lqba_pkg::MAX_RESET;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			max_q <= pwdata[15:0];
		end
	end

	// The request kind is held for the datapath's commit step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= lqba_pkg::REQ_REPORT;
		end else if (cmd.load) begin
			kind_q <= req_type;
		end
	end

	lqba_control u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lqba_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.max_bitrate         (max_q),
		.req_type            (kind_q),
		.link_quality        (link_quality),
		.link_bandwidth      (link_bandwidth),
		.retransmitted_count (retransmitted_count),
		.sent_count          (sent_count),
		.encode_bitrate      (encode_bitrate),
		.bitrate_changed     (bitrate_changed),
		.bandwidth_average   (bandwidth_average),
		.bitrate_average     (bitrate_average),
		.retransmitted_total (retransmitted_total),
		.sent_total          (sent_total)
	);
endmodule

### tb/link_quality_bitrate_adapter_tb.sv
`timescale 1ns / 100ps

module link_quality_bitrate_adapter_tb;

	// The run is stopped after this many clock cycles, whatever happens.
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int DRAIN_CYCLES = 400;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] ADDR_MAX_BITRATE = 2'd0;
	localparam logic [14:0] Q_FULL = 15'd25600;

	// Idling modes, one per phase of the run.
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [15:0] rate;
		logic        changed;
		logic [30:0] bw_avg;
		logic [15:0] rate_avg;
		logic [31:0] retx_total;
		logic [31:0] sent_total;
	} status_report_t;

	// A row of the directed table. Where typed is set, the bitrate and the
	// change flag are known up front and replace the predicted ones.
	typedef struct {
		logic [1:0]  req;
		logic [14:0] quality;
		logic [30:0] bw;
		logic [30:0] retx;
		logic [30:0] sent;
		bit          typed;
		logic [15:0] rate;
		logic        changed;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [14:0] link_quality;
	logic [30:0] link_bandwidth;
	logic [30:0] retransmitted_count;
	logic [30:0] sent_count;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] encode_bitrate;
	logic        bitrate_changed;
	logic [30:0] bandwidth_average;
	logic [15:0] bitrate_average;
	logic [31:0] retransmitted_total;
	logic [31:0] sent_total;

	link_quality_bitrate_adapter i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.req_type            (req_type),
		.link_quality        (link_quality),
		.link_bandwidth      (link_bandwidth),
		.retransmitted_count (retransmitted_count),
		.sent_count          (sent_count),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.encode_bitrate      (encode_bitrate),
		.bitrate_changed     (bitrate_changed),
		.bandwidth_average   (bandwidth_average),
		.bitrate_average     (bitrate_average),
		.retransmitted_total (retransmitted_total),
		.sent_total          (sent_total)
	);

	// Shadow copy of the adapter state, kept in step with accepted items.
	logic [15:0] max_rate;
	logic [15:0] rate_now;
	logic [14:0] prev_quality;
	logic [31:0] reports_seen;
	logic [30:0] bw_mean;
	logic [15:0] rate_mean;
	logic [31:0] retx_sum;
	logic [31:0] sent_sum;

	status_report_t pending_reports[$];
	idle_mode_t     idle_mode;
	int             error_count;
	int             cycle_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Cumulative mean step: mean + trunc((x - mean) / n), with n nonzero.
	function automatic longint unsigned mean_move(longint unsigned mean,
		longint unsigned x, longint unsigned n);
		if (x >= mean) begin
			return mean + (x - mean) / n;
		end
		return mean - (mean - x) / n;
	endfunction

	// Advances the shadow state by one item and returns the status it leaves.
	function automatic status_report_t adapt_rate(logic [1:0] req, logic [14:0] q,
		logic [30:0] bw, logic [30:0] retx, logic [30:0] sent);
		status_report_t res;
		longint c;
		longint m;
		longint p;
		longint delta;
		longint unsigned r;
		res.changed = 1'b0;
		c = longint'(rate_now);
		m = longint'(max_rate);
		p = longint'(prev_quality);
		delta = 0;
		case (req)
			lqba_pkg::REQ_REPORT: begin
				// A new integer part of the quality scales the rate by the ratio.
				if (p != 0 && (q >> 8) != (p >> 8)) begin
					delta = (c * longint'(q)) / p - c;
				end
				// Staying at full quality creeps the rate up toward the limit.
				if ((p >> 8) == lqba_pkg::FULL_QUALITY
					&& (q >> 8) == lqba_pkg::FULL_QUALITY && c < m) begin
					delta = (c * c) / m;
				end
				if (delta != 0 || c > m) begin
					r = longint'(c + delta / 2) & 64'hFFFF;
					if (r > m) begin
						r = m;
					end
					if (r < lqba_pkg::RATE_FLOOR) begin
						r = lqba_pkg::RATE_FLOOR;
					end
					rate_now = r[15:0];
					res.changed = 1'b1;
				end
				if (reports_seen != 32'hFFFF_FFFF) begin
					reports_seen++;
				end
				bw_mean = 31'(mean_move(bw_mean, bw, reports_seen));
				rate_mean = 16'(mean_move(rate_mean, rate_now, reports_seen));
				retx_sum = retx_sum + 32'(retx);
				sent_sum = sent_sum + 32'(sent);
				prev_quality = q;
			end
			lqba_pkg::REQ_START: begin
				rate_now = max_rate;
			end
			lqba_pkg::REQ_STOP: begin
				reports_seen = '0;
				bw_mean = '0;
				rate_mean = '0;
				retx_sum = '0;
				sent_sum = '0;
			end
			default: begin
			end
		endcase
		res.rate = rate_now;
		res.bw_avg = bw_mean;
		res.rate_avg = rate_mean;
		res.retx_total = retx_sum;
		res.sent_total = sent_sum;
		return res;
	endfunction

	// Offers one item, optionally after a random idle gap, and records the
	// expected status once the block takes it. Called and returns at a
	// falling edge.
	task automatic send_item(logic [1:0] req, logic [14:0] q, logic [30:0] bw,
		logic [30:0] retx, logic [30:0] sent, bit typed, logic [15:0] t_rate,
		logic t_changed);
		status_report_t res;
		if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
			while ($urandom_range(99) < (idle_mode == IDLE_SENDER ? 62 : 19)) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		req_type = req;
		link_quality = q;
		link_bandwidth = bw;
		retransmitted_count = retx;
		sent_count = sent;
		do begin
			@(posedge clk);
		end while (in_stall);
		res = adapt_rate(req, q, bw, retx, sent);
		if (typed) begin
			res.rate = t_rate;
			res.changed = t_changed;
		end
		pending_reports.insert(pending_reports.size(), res);
		@(negedge clk);
	endtask

	// Waits at falling edges until every expected item has come back.
	task automatic drain();
		in_valid = 1'b0;
		while (pending_reports.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// APB write of the rate limit: setup cycle, then access cycle. The block
	// must be idle, so the caller drains first.
	task automatic write_max_rate(logic [15:0] value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_MAX_BITRATE;
		pwdata = {16'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		max_rate = value;
	endtask

	// Random quality: mostly full quality or a new fraction of the present
	// integer part, which is what drives the rate rules, otherwise anything.
	function automatic logic [14:0] pick_quality();
		int sel;
		logic [14:0] q;
		sel = $urandom_range(99);
		if (sel < 35) begin
			q = Q_FULL;
		end else if (sel < 60) begin
			q = {prev_quality[14:8], 8'($urandom)};
			if (q > Q_FULL) begin
				q = Q_FULL;
			end
		end else if (sel < 95) begin
			q = 15'($urandom_range(25600));
		end else begin
			q = 15'($urandom);
		end
		return q;
	endfunction

	task automatic send_random(int count);
		int sel;
		logic [1:0] req;
		logic [30:0] bw;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			if (sel < 86) begin
				req = lqba_pkg::REQ_REPORT;
			end else if (sel < 93) begin
				req = lqba_pkg::REQ_START;
			end else if (sel < 97) begin
				req = lqba_pkg::REQ_STOP;
			end else begin
				req = REQ_UNUSED;
			end
			// Realistic bandwidths most of the time, the full range now and then.
			bw = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(50_000_000));
			send_item(req, pick_quality(), bw, 31'($urandom), 31'($urandom),
				1'b0, '0, 1'b0);
		end
	endtask

	// Receiver side: stalls at random in the phases that ask for it.
	always @(negedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 62);
			IDLE_BOTH: out_stall <= ($urandom_range(99) < 19);
			default: out_stall <= 1'b0;
		endcase
	end

	// Every accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		status_report_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: result with nothing expected: rate %0d", $time,
					encode_bitrate);
				error_count++;
			end else begin
				exp_res = pending_reports.pop_front();
				if (encode_bitrate !== exp_res.rate) begin
					$display("%0t: encode_bitrate expected %0d, got %0d", $time,
						exp_res.rate, encode_bitrate);
					error_count++;
				end
				if (bitrate_changed !== exp_res.changed) begin
					$display("%0t: bitrate_changed expected %0d, got %0d", $time,
						exp_res.changed, bitrate_changed);
					error_count++;
				end
				if (bandwidth_average !== exp_res.bw_avg) begin
					$display("%0t: bandwidth_average expected %0d, got %0d", $time,
						exp_res.bw_avg, bandwidth_average);
					error_count++;
				end
				if (bitrate_average !== exp_res.rate_avg) begin
					$display("%0t: bitrate_average expected %0d, got %0d", $time,
						exp_res.rate_avg, bitrate_average);
					error_count++;
				end
				if (retransmitted_total !== exp_res.retx_total) begin
					$display("%0t: retransmitted_total expected %0d, got %0d", $time,
						exp_res.retx_total, retransmitted_total);
					error_count++;
				end
				if (sent_total !== exp_res.sent_total) begin
					$display("%0t: sent_total expected %0d, got %0d", $time,
						exp_res.sent_total, sent_total);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		directed_row_t rows[$];
		logic [15:0] limits[$];
		idle_mode = IDLE_NONE;
		error_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		req_type = lqba_pkg::REQ_REPORT;
		link_quality = '0;
		link_bandwidth = '0;
		retransmitted_count = '0;
		sent_count = '0;
		max_rate = lqba_pkg::MAX_RESET;
		rate_now = '0;
		prev_quality = '0;
		reports_seen = '0;
		bw_mean = '0;
		rate_mean = '0;
		retx_sum = '0;
		sent_sum = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. The typed rows follow the rate by hand from reset:
		// a report with no previous quality leaves the rate alone, a start
		// loads the limit, quality drops halve the ratio step, and the floor
		// of 1000 catches the last drop.
		rows = '{
			'{lqba_pkg::REQ_REPORT, 15'd0, 31'd0, 31'd0, 31'd0, 1, 16'd0, 1'b0},
			'{lqba_pkg::REQ_START, 15'd1234, 31'd5, 31'd5, 31'd5, 1, 16'd5000, 1'b0},
			'{lqba_pkg::REQ_REPORT, Q_FULL, 31'd1000, 31'd1, 31'd2, 1, 16'd5000, 1'b0},
			'{lqba_pkg::REQ_REPORT, Q_FULL, 31'd3000, 31'd3, 31'd4, 1, 16'd5000, 1'b0},
			'{lqba_pkg::REQ_REPORT, 15'd12800, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
				31'h7FFF_FFFF, 1, 16'd3750, 1'b1},
			'{lqba_pkg::REQ_REPORT, 15'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
				31'h7FFF_FFFF, 1, 16'd1875, 1'b1},
			'{lqba_pkg::REQ_REPORT, 15'h7FFF, 31'd0, 31'd0, 31'd0, 1, 16'd1875, 1'b0},
			'{lqba_pkg::REQ_REPORT, 15'd256, 31'h5555_5555, 31'h2AAA_AAAA,
				31'h5555_5555, 1, 16'd1000, 1'b1},
			'{lqba_pkg::REQ_STOP, 15'h7FFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
				31'h7FFF_FFFF, 1, 16'd1000, 1'b0},
			'{REQ_UNUSED, 15'd25600, 31'd77, 31'd77, 31'd77, 1, 16'd1000, 1'b0},
			'{lqba_pkg::REQ_START, 15'd0, 31'd0, 31'd0, 31'd0, 1, 16'd5000, 1'b0},
			'{lqba_pkg::REQ_REPORT, 15'd12800, 31'd100, 31'd9, 31'd90, 0, '0, 1'b0},
			'{lqba_pkg::REQ_REPORT, 15'd19200, 31'd200, 31'd8, 31'd80, 0, '0, 1'b0},
			'{lqba_pkg::REQ_REPORT, Q_FULL, 31'd300, 31'd7, 31'd70, 0, '0, 1'b0},
			'{lqba_pkg::REQ_REPORT, 15'd25700, 31'd400, 31'd6, 31'd60, 0, '0, 1'b0},
			'{lqba_pkg::REQ_REPORT, 15'd12900, 31'd500, 31'd5, 31'd50, 0, '0, 1'b0},
			'{lqba_pkg::REQ_REPORT, 15'd12801, 31'd600, 31'd4, 31'd40, 0, '0, 1'b0},
			'{lqba_pkg::REQ_STOP, 15'd0, 31'd0, 31'd0, 31'd0, 0, '0, 1'b0},
			'{lqba_pkg::REQ_REPORT, 15'd25600, 31'd1, 31'd1, 31'd1, 0, '0, 1'b0}
		};
		foreach (rows[i]) begin
			send_item(rows[i].req, rows[i].quality, rows[i].bw, rows[i].retx,
				rows[i].sent, rows[i].typed, rows[i].rate, rows[i].changed);
		end
		drain();

		// Random part: one phase per rate limit, the idling mode cycling through
		// all four. Raising the limit without a start leaves the rate below it,
		// which is what opens the full quality rule; lowering it below the rate
		// forces a clamp on the next report.
		limits = '{16'd65535, 16'd0, 16'd999, 16'd1000, 16'($urandom),
			16'd20000, 16'd65535, 16'($urandom_range(1000, 8000)), lqba_pkg::MAX_RESET};
		foreach (limits[i]) begin
			idle_mode = idle_mode_t'(i % 4);
			write_max_rate(limits[i]);
			send_random(70);
			// Hold the sender until the block has answered everything.
			if (i == 2) begin
				drain();
			end
			send_random(72);
			drain();
		end

		in_valid = 1'b0;
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
